// File: hdl/pidc_pkg.sv
// Shared types and constants for the PID step block.
// No dependencies; imported by pidc_datapath and pid_step_with_clamps.
package pidc_pkg;

  localparam int unsigned GainW  = 24;
  localparam int unsigned LimitW = 31;
  localparam int unsigned InW    = 31;
  localparam int unsigned ErrW   = 32;
  localparam int unsigned DriveW = 32;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 31;

  localparam logic [CfgIdxW-1:0] CfgPropGain   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgIntegGain  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgDerivGain  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgIntegLimit = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgDriveLimit = 3'd4;

  localparam logic [GainW-1:0]  PropGainRst   = 24'd983040;
  localparam logic [GainW-1:0]  IntegGainRst  = 24'd0;
  localparam logic [GainW-1:0]  DerivGainRst  = 24'd0;
  localparam logic [LimitW-1:0] IntegLimitRst = 31'd19660800;
  localparam logic [LimitW-1:0] DriveLimitRst = 31'd52428800;

  localparam logic ModeRun   = 1'b0;
  localparam logic ModeClear = 1'b1;

  typedef struct packed {
    logic [GainW-1:0]  prop_gain;
    logic [GainW-1:0]  integ_gain;
    logic [GainW-1:0]  deriv_gain;
    logic [LimitW-1:0] integ_limit;
    logic [LimitW-1:0] drive_limit;
  } cfg_t;

endpackage

// File: hdl/pidc_datapath.sv
// Combinational PID step: error, integral update with clamp, drive sum with clamp.
// Depends on pidc_pkg for field widths and the configuration struct.
module pidc_datapath import pidc_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  cfg_t                          cfg_i,
  input  logic signed [InW-1:0]         setpoint_i,
  input  logic signed [InW-1:0]         measurement_i,
  input  logic signed [DATA_WIDTH-1:0]  integ_acc_i,
  input  logic signed [DATA_WIDTH-1:0]  prev_error_i,
  output logic signed [DATA_WIDTH-1:0]  integ_acc_o,
  output logic signed [DATA_WIDTH-1:0]  prev_error_o,
  output logic signed [DriveW-1:0]      drive_o
);

  localparam int unsigned MaxW      = (DATA_WIDTH > ErrW) ? DATA_WIDTH : ErrW;
  localparam int unsigned PProdW    = ErrW + GainW + 1;
  localparam int unsigned PShiftW   = PProdW - 16;
  localparam int unsigned IntegSumW = ((DATA_WIDTH > PShiftW) ? DATA_WIDTH : PShiftW) + 1;
  localparam int unsigned DiffW     = MaxW + 1;
  localparam int unsigned DProdW    = DiffW + GainW + 1;
  localparam int unsigned DShiftW   = DProdW - 16;
  localparam int unsigned DriveSumW = DShiftW + 2;

  logic signed [ErrW-1:0]      err;
  logic signed [PProdW-1:0]    pprod;
  logic signed [PProdW-1:0]    iprod;
  logic signed [PShiftW-1:0]   pterm;
  logic signed [PShiftW-1:0]   iterm;
  logic signed [IntegSumW-1:0] integ_sum;
  logic signed [IntegSumW-1:0] integ_lim;
  logic signed [IntegSumW-1:0] integ_clamp;
  logic signed [ErrW-1:0]      integ_nar;
  logic signed [MaxW-1:0]      integ_wide;
  logic signed [MaxW-1:0]      err_wide;
  logic signed [DiffW-1:0]     diff;
  logic signed [DProdW-1:0]    dprod;
  logic signed [DShiftW-1:0]   dterm;
  logic signed [DriveSumW-1:0] drive_sum;
  logic signed [DriveSumW-1:0] drive_lim;
  logic signed [DriveSumW-1:0] drive_clamp;

  always_comb begin
    err   = ErrW'(setpoint_i) - ErrW'(measurement_i);
    pprod = $signed({1'b0, cfg_i.prop_gain}) * err;
    iprod = $signed({1'b0, cfg_i.integ_gain}) * err;
    pterm = pprod[PProdW-1:16];
    iterm = iprod[PProdW-1:16];

    integ_sum = IntegSumW'(integ_acc_i) + IntegSumW'(iterm);
    integ_lim = $signed({{(IntegSumW-LimitW){1'b0}}, cfg_i.integ_limit});
    if (integ_sum > integ_lim) begin
      integ_clamp = integ_lim;
    end else if (integ_sum < -integ_lim) begin
      integ_clamp = -integ_lim;
    end else begin
      integ_clamp = integ_sum;
    end
    integ_nar   = integ_clamp[ErrW-1:0];
    integ_wide  = MaxW'(integ_nar);
    integ_acc_o = integ_wide[DATA_WIDTH-1:0];

    err_wide     = MaxW'(err);
    prev_error_o = err_wide[DATA_WIDTH-1:0];

    diff  = DiffW'(err) - DiffW'(prev_error_i);
    dprod = $signed({1'b0, cfg_i.deriv_gain}) * diff;
    dterm = dprod[DProdW-1:16];

    drive_sum = DriveSumW'(pterm) + DriveSumW'(integ_acc_o) + DriveSumW'(dterm);
    drive_lim = $signed({{(DriveSumW-LimitW){1'b0}}, cfg_i.drive_limit});
    if (drive_sum > drive_lim) begin
      drive_clamp = drive_lim;
    end else if (drive_sum < -drive_lim) begin
      drive_clamp = -drive_lim;
    end else begin
      drive_clamp = drive_sum;
    end
    drive_o = drive_clamp[DriveW-1:0];
  end

endmodule

// File: hdl/pid_step_with_clamps.sv
// Positional PID controller step with integral and output clamps, Q16.16.
// Depends on pidc_pkg and pidc_datapath.
//
// Each run beat on the slave stream forms error = setpoint - measurement,
// updates the integral (ki * error, clamped to +/- integ_limit) and emits one
// drive beat: kp * error + integral + kd * (error - previous error), clamped to
// +/- drive_limit. A clear beat (tuser = 1) zeroes the integral and emits
// nothing. Gain products are floored to Q16.16. A beat is taken every cycle
// while the output is not stalled: it is held in the input register, the
// integral and previous-error registers are updated as it passes the single
// combinational pass, and the drive is loaded into the output register, which
// drives tvalid. The throughput limit is the integral feedback loop, closed
// within that one pass. Configuration must be written only while no beat is in
// flight; the block itself does not enforce this.
module pid_step_with_clamps import pidc_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [30:0] setpoint, [61:31] measurement, [63:62] zero
  input  logic [63:0]         s_axis_tdata_i,
  // [0] mode
  input  logic                s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [31:0] drive
  output logic [DriveW-1:0]   m_axis_tdata_o
);

  cfg_t cfg_q;

  logic                  in_valid_q;
  logic                  in_mode_q;
  logic signed [InW-1:0] setpoint_q;
  logic signed [InW-1:0] measurement_q;

  logic                         out_valid_q;
  logic                         out_valid_d;
  logic signed [DriveW-1:0]     drive_q;
  logic signed [DriveW-1:0]     drive_d;

  logic signed [DATA_WIDTH-1:0] integ_acc_q;
  logic signed [DATA_WIDTH-1:0] integ_acc_d;
  logic signed [DATA_WIDTH-1:0] prev_error_q;
  logic signed [DATA_WIDTH-1:0] prev_error_d;

  logic out_free;
  logic fire;
  logic fire_run;
  logic in_take;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain   <= PropGainRst;
      cfg_q.integ_gain  <= IntegGainRst;
      cfg_q.deriv_gain  <= DerivGainRst;
      cfg_q.integ_limit <= IntegLimitRst;
      cfg_q.drive_limit <= DriveLimitRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgPropGain:   cfg_q.prop_gain   <= cfg_data_i[GainW-1:0];
        CfgIntegGain:  cfg_q.integ_gain  <= cfg_data_i[GainW-1:0];
        CfgDerivGain:  cfg_q.deriv_gain  <= cfg_data_i[GainW-1:0];
        CfgIntegLimit: cfg_q.integ_limit <= cfg_data_i[LimitW-1:0];
        CfgDriveLimit: cfg_q.drive_limit <= cfg_data_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign fire            = in_valid_q && ((in_mode_q == ModeClear) || out_free);
  assign fire_run        = fire && (in_mode_q == ModeRun);
  assign s_axis_tready_o = !in_valid_q || fire;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  // hold the beat until the pass can advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_mode_q     <= s_axis_tuser_i;
      setpoint_q    <= s_axis_tdata_i[InW-1:0];
      measurement_q <= s_axis_tdata_i[2*InW-1:InW];
    end
  end

  logic signed [DATA_WIDTH-1:0] integ_step;
  logic signed [DATA_WIDTH-1:0] prev_step;

  pidc_datapath #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_datapath (
    .cfg_i        (cfg_q),
    .setpoint_i   (setpoint_q),
    .measurement_i(measurement_q),
    .integ_acc_i  (integ_acc_q),
    .prev_error_i (prev_error_q),
    .integ_acc_o  (integ_step),
    .prev_error_o (prev_step),
    .drive_o      (drive_d)
  );

  always_comb begin
    integ_acc_d  = integ_acc_q;
    prev_error_d = prev_error_q;
    if (fire) begin
      if (in_mode_q == ModeClear) begin
        integ_acc_d = '0;
      end else begin
        integ_acc_d  = integ_step;
        prev_error_d = prev_step;
      end
    end
    out_valid_d = (out_valid_q && !m_axis_tready_i) || fire_run;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_acc_q  <= '0;
      prev_error_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      integ_acc_q  <= integ_acc_d;
      prev_error_q <= prev_error_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_run) begin
      drive_q <= drive_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = drive_q;

endmodule

// File: tb/testbench.sv
// Self-checking bench for pid_step_with_clamps: stream driver, stream monitor and a
// Q16.16 PID predictor with integral and drive clamps.
// Depends on pidc_pkg and the block's RTL only.
`timescale 1ns / 100ps

module testbench;
  import pidc_pkg::*;

  localparam int unsigned DataW      = 32;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned Latency    = 6;
  localparam logic [CfgIdxW-1:0] CfgSpareLo = CfgDriveLimit + 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = {CfgIdxW{1'b1}};
  localparam logic [InW-1:0] InMax = {1'b0, {(InW-1){1'b1}}};
  localparam logic [InW-1:0] InMin = {1'b1, {(InW-1){1'b0}}};
  localparam logic [CfgDataW-1:0] CfgAllOnes = {CfgDataW{1'b1}};

  typedef struct packed {
    logic           mode;
    logic [InW-1:0] setpoint;
    logic [InW-1:0] measurement;
  } pid_item_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                cfg_ready;
  logic                src_valid = 1'b0;
  logic                src_ready;
  logic [63:0]         src_tdata = '0;
  logic                src_tuser = 1'b0;
  logic                drv_valid;
  logic                snk_ready = 1'b0;
  logic [DriveW-1:0]   drv_tdata;

  pid_step_with_clamps #(
    .DATA_WIDTH(DataW)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .s_axis_tvalid_i(src_valid),
    .s_axis_tready_o(src_ready),
    .s_axis_tdata_i (src_tdata),
    .s_axis_tuser_i (src_tuser),
    .m_axis_tvalid_o(drv_valid),
    .m_axis_tready_i(snk_ready),
    .m_axis_tdata_o (drv_tdata)
  );

  always #5 clk_i = ~clk_i;

  pid_item_t         pending[$];
  logic [DriveW-1:0] drive_q[$];

  logic [GainW-1:0]  kp = PropGainRst;
  logic [GainW-1:0]  ki = IntegGainRst;
  logic [GainW-1:0]  kd = DerivGainRst;
  logic [LimitW-1:0] integ_lim = IntegLimitRst;
  logic [LimitW-1:0] drive_lim = DriveLimitRst;
  logic signed [63:0] integ_acc = '0;
  logic signed [63:0] last_err = '0;

  int errors = 0;
  int beats_sent = 0;
  int clears_sent = 0;
  int drives_seen = 0;
  int cfg_writes = 0;
  int cycles = 0;

  function automatic logic signed [63:0] clamp_mag(logic signed [63:0] v, logic [LimitW-1:0] lim);
    logic signed [63:0] l;
    l = $signed({33'd0, lim});
    if (v > l) return l;
    if (v < -l) return -l;
    return v;
  endfunction

  function automatic logic signed [63:0] scale_q16(logic [GainW-1:0] g, logic signed [63:0] x);
    logic signed [63:0] p;
    p = $signed({40'd0, g}) * x;
    return p >>> 16;
  endfunction

  function automatic logic signed [63:0] wrap_dw(logic signed [63:0] v);
    logic signed [63:0] r;
    r = v <<< (64 - DataW);
    return r >>> (64 - DataW);
  endfunction

  task automatic predict_drive(input pid_item_t it);
    logic signed [63:0] err, integ, drv;
    if (it.mode == ModeClear) begin
      integ_acc = '0;
    end else begin
      err = $signed({{33{it.setpoint[InW-1]}}, it.setpoint})
          - $signed({{33{it.measurement[InW-1]}}, it.measurement});
      integ = wrap_dw(clamp_mag(integ_acc + scale_q16(ki, err), integ_lim));
      integ_acc = integ;
      drv = scale_q16(kp, err) + integ + scale_q16(kd, err - last_err);
      drv = clamp_mag(drv, drive_lim);
      last_err = wrap_dw(err);
      drive_q.push_back(drv[DriveW-1:0]);
    end
  endtask

  // stream driver: bursts of random length, random gaps between them
  pid_item_t cur_item;
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk_i) begin
    logic nxt_valid;
    nxt_valid = src_valid;
    if (src_valid && src_ready) begin
      predict_drive(cur_item);
      beats_sent++;
      if (cur_item.mode == ModeClear) clears_sent++;
      nxt_valid = 1'b0;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 8);
        gap_left = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10);
      end
    end
    if (rst_ni && !nxt_valid) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending.size() != 0) begin
        cur_item = pending.pop_front();
        src_tdata <= {2'b00, cur_item.measurement, cur_item.setpoint};
        src_tuser <= cur_item.mode;
        nxt_valid = 1'b1;
      end
    end
    src_valid <= nxt_valid;
  end

  // drive monitor and receiver stall pattern
  int rdy_mode = 0;
  int mode_left = 0;
  int run_left = 0;
  logic rdy_lvl = 1'b1;

  always @(posedge clk_i) begin
    logic [DriveW-1:0] want;
    if (rst_ni && drv_valid && snk_ready) begin
      if (drive_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected drive beat, expected none, got %h", $time, drv_tdata);
      end else begin
        want = drive_q.pop_front();
        drives_seen++;
        if (drv_tdata !== want) begin
          errors++;
          $display("%0t: drive mismatch, expected %h, got %h", $time, want, drv_tdata);
        end
      end
    end
    if (mode_left == 0) begin
      rdy_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(64, 400);
      run_left = 0;
    end
    mode_left--;
    if (run_left == 0) begin
      case (rdy_mode)
        0: begin
          rdy_lvl = 1'b1;
          run_left = 1;
        end
        1: begin
          rdy_lvl = 1'($urandom_range(0, 1));
          run_left = 1;
        end
        2: begin
          rdy_lvl = !rdy_lvl;
          run_left = rdy_lvl ? $urandom_range(1, 3) : 1;
        end
        default: begin
          rdy_lvl = !rdy_lvl;
          run_left = $urandom_range(1, 12);
        end
      endcase
    end
    run_left--;
    snk_ready <= rdy_lvl;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout, %0d drive beats still awaited", $time, drive_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CfgPropGain:   kp = val[GainW-1:0];
      CfgIntegGain:  ki = val[GainW-1:0];
      CfgDerivGain:  kd = val[GainW-1:0];
      CfgIntegLimit: integ_lim = val[LimitW-1:0];
      CfgDriveLimit: drive_lim = val[LimitW-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic set_all(input logic [CfgDataW-1:0] p, input logic [CfgDataW-1:0] i,
                         input logic [CfgDataW-1:0] d, input logic [CfgDataW-1:0] il,
                         input logic [CfgDataW-1:0] dl);
    write_reg(CfgPropGain, p);
    write_reg(CfgIntegGain, i);
    write_reg(CfgDerivGain, d);
    write_reg(CfgIntegLimit, il);
    write_reg(CfgDriveLimit, dl);
  endtask

  task automatic queue_step(input logic mode, input logic [InW-1:0] sp, input logic [InW-1:0] ms);
    pid_item_t it;
    it.mode = mode;
    it.setpoint = sp;
    it.measurement = ms;
    pending.push_back(it);
  endtask

  // hold until every beat is out, then let the pipeline empty
  task automatic settle();
    do @(negedge clk_i); while (pending.size() != 0 || src_valid || drive_q.size() != 0);
    repeat (Latency) @(posedge clk_i);
  endtask

  function automatic logic [CfgDataW-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return CfgAllOnes;
      2, 3: return CfgDataW'($urandom_range(0, 262143));
      4: return CfgDataW'({$urandom_range(0, 127), 8'd0, 16'd0} | $urandom_range(0, 65535));
      default: return CfgDataW'($urandom);
    endcase
  endfunction

  function automatic logic [CfgDataW-1:0] pick_limit();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return CfgAllOnes;
      2, 3: return CfgDataW'($urandom_range(0, 67108864));
      default: return CfgDataW'($urandom);
    endcase
  endfunction

  task automatic random_phase(input int n);
    int seg_left, bias, sp, d, r;
    set_all(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_limit());
    if ($urandom_range(0, 2) == 0)
      write_reg(CfgIdxW'($urandom_range(CfgSpareLo, CfgSpareHi)), CfgDataW'($urandom));
    seg_left = 0;
    bias = 0;
    repeat (n) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(5, 40);
        bias = int'($urandom_range(0, 8388608)) - 4194304;
      end
      seg_left--;
      r = $urandom_range(0, 99);
      if (r < 6) begin
        queue_step(ModeClear, InW'($urandom), InW'($urandom));
      end else if (r < 26) begin
        queue_step(ModeRun, InW'($urandom), InW'($urandom));
      end else begin
        sp = int'($urandom_range(0, 33554432)) - 16777216;
        d = bias + int'($urandom_range(0, 131072)) - 65536;
        queue_step(ModeRun, InW'(sp), InW'(sp - d));
      end
    end
    settle();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: saturation both ways and tiny errors
    queue_step(ModeRun, '0, '0);
    queue_step(ModeRun, InMax, InMin);
    queue_step(ModeRun, InMin, InMax);
    queue_step(ModeRun, InW'(1), '0);
    queue_step(ModeRun, '0, InW'(1));
    queue_step(ModeClear, InMax, InMin);
    queue_step(ModeRun, InMax, InMax);
    settle();

    // integral clamp both ways, clear keeps the previous error
    set_all(CfgDataW'(65536), CfgDataW'(32768), CfgDataW'(131072),
            CfgDataW'(655360), CfgAllOnes);
    repeat (4) queue_step(ModeRun, InW'(327680), '0);
    queue_step(ModeClear, '0, '0);
    queue_step(ModeRun, InW'(327680), '0);
    repeat (5) queue_step(ModeRun, '0, InW'(327680));
    queue_step(ModeRun, '0, InW'(1));
    queue_step(ModeRun, InMax, InMin);
    settle();

    // zero limits clamp everything to zero
    set_all(CfgAllOnes, CfgAllOnes, CfgAllOnes, '0, '0);
    queue_step(ModeRun, InMax, InMin);
    queue_step(ModeRun, InMin, InMax);
    queue_step(ModeRun, InW'(12345), InW'(54321));
    settle();

    // largest gains and limits
    set_all(CfgAllOnes, CfgAllOnes, CfgAllOnes, CfgAllOnes, CfgAllOnes);
    queue_step(ModeRun, InMax, InMin);
    queue_step(ModeRun, InMin, InMax);
    queue_step(ModeRun, InMin, InMax);
    settle();

    repeat (10) random_phase(170);

    $display("Sent %0d step beats (%0d clears) under %0d register writes; checked %0d drive beats",
             beats_sent, clears_sent, cfg_writes, drives_seen);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", errors);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
